// File: rtl/subset_prim_mst_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the subset Prim core
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SUBSET_PRIM_MST_CORE_DEFINES_SVH
`define SUBSET_PRIM_MST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPM_ASSERT(lbl, clk, rstn, prop, msg)
`define SPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// Subset Prim package
// Field widths, op and scan mode codes, controller command and status words.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int W_W   = 16;
    localparam int SUM_W = 20;
    localparam int CFG_W = 5;

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_NODE  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_INIT  = 2'd1;
    localparam logic [1:0] MODE_FIND  = 2'd2;
    localparam logic [1:0] MODE_RELAX = 2'd3;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_PICK_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;

    typedef struct packed {
        logic [1:0] mode;
        logic       scan_rst;
        logic       clr_run;
        logic       seed;
        logic       take;
        logic       set_fail;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic first_found;
        logic best_found;
        logic pending;
        logic rounds_done;
        logic out_busy;
    } sts_t;

endpackage

// File: rtl/subset_prim_mst_core.sv
// ----------------------------------------------------------------------------
// Subset Prim minimum spanning tree core
// Load words (edge or node) take one cycle each and never stall while idle.
// A start word stalls the input until its result is loaded; its init scan spans
// n = min(node_count, MAX_NODES) nodes, and each round is one find scan and one
// relax scan over the single read port of the weight and distance memories.
// Reset clears marks, control and config (both 16); memories keep contents.
// ----------------------------------------------------------------------------
module subset_prim_mst_core
#(
    parameter int MAX_NODES = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [3:0]                row,
    input  logic [3:0]                col,
    input  logic [spm_pkg::W_W-1:0]   edge_weight,
    input  logic [spm_pkg::W_W-1:0]   node_value,
    input  logic                      node_selected,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [spm_pkg::SUM_W-1:0] tree_weight,
    output logic [spm_pkg::SUM_W-1:0] value_sum,
    output logic                      failed,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [spm_pkg::CFG_W-1:0] cfg_wr_data
);

    spm_pkg::cmd_t cmd;
    spm_pkg::sts_t sts;
    logic          load_en;

    assign load_en = in_valid && !in_stall;

    spm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    spm_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .load_en       (load_en),
        .op            (op),
        .row           (row),
        .col           (col),
        .edge_weight   (edge_weight),
        .node_value    (node_value),
        .node_selected (node_selected),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .tree_weight   (tree_weight),
        .value_sum     (value_sum),
        .failed        (failed)
    );

endmodule

// File: rtl/spm_ctrl.sv
// ----------------------------------------------------------------------------
// Subset Prim controller
// Sequences the init scan, the seed, and the find and relax scans per round.
// ----------------------------------------------------------------------------
module spm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    op,
    input  spm_pkg::sts_t sts,
    output logic          in_stall,
    output spm_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_RELAX = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (op == spm_pkg::OP_START))
                begin
                    cmd.clr_run  = 1'b1;
                    cmd.scan_rst = 1'b1;
                    state_next   = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.mode = spm_pkg::MODE_INIT;
                if (sts.scan_done)
                begin
                    if (sts.first_found)
                    begin
                        cmd.seed   = 1'b1;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cmd.set_fail = 1'b1;
                        state_next   = S_DONE;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.rounds_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_rst = 1'b1;
                    state_next   = S_FIND;
                end
            end
            S_FIND:
            begin
                cmd.mode = spm_pkg::MODE_FIND;
                if (sts.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (sts.best_found)
                begin
                    cmd.take     = 1'b1;
                    cmd.scan_rst = 1'b1;
                    state_next   = S_RELAX;
                end
                else
                begin
                    cmd.set_fail = sts.pending;
                    state_next   = S_DONE;
                end
            end
            S_RELAX:
            begin
                cmd.mode = spm_pkg::MODE_RELAX;
                if (sts.scan_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/spm_dpath.sv
// ----------------------------------------------------------------------------
// Subset Prim datapath
// Weight, value and distance memories, node marks, scan pipeline and sums.
// ----------------------------------------------------------------------------
`include "subset_prim_mst_core_defines.svh"

module spm_dpath
#(
    parameter int MAX_NODES = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  spm_pkg::cmd_t             cmd,
    output spm_pkg::sts_t             sts,
    input  logic                      load_en,
    input  logic [1:0]                op,
    input  logic [3:0]                row,
    input  logic [3:0]                col,
    input  logic [spm_pkg::W_W-1:0]   edge_weight,
    input  logic [spm_pkg::W_W-1:0]   node_value,
    input  logic                      node_selected,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [spm_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic [spm_pkg::SUM_W-1:0] tree_weight,
    output logic [spm_pkg::SUM_W-1:0] value_sum,
    output logic                      failed
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [spm_pkg::SUM_W-1:0] sat_add(
        input logic [spm_pkg::SUM_W-1:0] a,
        input logic [spm_pkg::W_W-1:0]   b
    );
        logic [spm_pkg::SUM_W:0] s;
        s = {1'b0, a} + (spm_pkg::SUM_W+1)'(b);
        return s[spm_pkg::SUM_W] ? spm_pkg::SUM_MAX : s[spm_pkg::SUM_W-1:0];
    endfunction

    logic [spm_pkg::W_W-1:0]   weight_mem [DEPTH];
    logic [spm_pkg::W_W-1:0]   value_mem  [MAX_NODES];
    logic [spm_pkg::W_W-1:0]   dist_mem   [MAX_NODES];

    logic [spm_pkg::CFG_W-1:0] node_count_reg;
    logic [spm_pkg::CFG_W-1:0] pick_limit_reg;
    logic [MAX_NODES-1:0]      sel_reg;
    logic [MAX_NODES-1:0]      visited_reg;
    logic [MAX_NODES-1:0]      dvld_reg;
    logic [CW-1:0]             scan_reg;
    logic                      rd_vld_reg;
    logic [NW-1:0]             rd_idx_reg;
    logic [spm_pkg::W_W-1:0]   w_q_reg;
    logic [spm_pkg::W_W-1:0]   v_q_reg;
    logic [spm_pkg::W_W-1:0]   d_q_reg;
    logic [NW-1:0]             first_reg;
    logic                      first_found_reg;
    logic [spm_pkg::W_W-1:0]   least_reg;
    logic [NW-1:0]             pick_reg;
    logic                      best_found_reg;
    logic                      pending_reg;
    logic [AW-1:0]             pick_base_reg;
    logic [CW-1:0]             rounds_reg;
    logic [spm_pkg::SUM_W-1:0] tree_reg;
    logic [spm_pkg::SUM_W-1:0] vsum_reg;
    logic                      fail_reg;
    logic                      out_valid_reg;
    logic [spm_pkg::SUM_W-1:0] tree_out_reg;
    logic [spm_pkg::SUM_W-1:0] vsum_out_reg;
    logic                      failed_out_reg;

    logic [CW-1:0]             n_eff;
    logic [NW-1:0]             row_idx;
    logic [NW-1:0]             col_idx;
    logic                      edge_wr;
    logic                      node_wr;
    logic [AW-1:0]             wr_addr;
    logic [NW-1:0]             scan_idx;
    logic                      issue;
    logic [AW-1:0]             rd_addr_w;
    logic                      cand;
    logic                      relax_wr;
    logic                      find_hit;
    logic                      init_hit;
    logic                      dist_we;
    logic [NW-1:0]             dist_waddr;
    logic [spm_pkg::W_W-1:0]   dist_wdata;

    always_comb
    begin
        if (32'(node_count_reg) > MAX_NODES)
        begin
            n_eff = CW'(MAX_NODES);
        end
        else
        begin
            n_eff = CW'(node_count_reg);
        end
    end

    assign row_idx   = NW'(row);
    assign col_idx   = NW'(col);
    assign edge_wr   = load_en && (op == spm_pkg::OP_EDGE) &&
                       (32'(row) < MAX_NODES) && (32'(col) < MAX_NODES);
    assign node_wr   = load_en && (op == spm_pkg::OP_NODE) && (32'(row) < MAX_NODES);
    assign wr_addr   = AW'(AW'(row_idx) * AW'(MAX_NODES) + AW'(col_idx));

    assign scan_idx  = scan_reg[NW-1:0];
    assign issue     = (cmd.mode != spm_pkg::MODE_NONE) && (scan_reg < n_eff);
    assign rd_addr_w = AW'(pick_base_reg + AW'(scan_idx));

    assign cand      = sel_reg[rd_idx_reg] && !visited_reg[rd_idx_reg];
    assign init_hit  = rd_vld_reg && (cmd.mode == spm_pkg::MODE_INIT) && sel_reg[rd_idx_reg];
    assign find_hit  = rd_vld_reg && (cmd.mode == spm_pkg::MODE_FIND) && cand &&
                       dvld_reg[rd_idx_reg] && (!best_found_reg || (d_q_reg < least_reg));
    assign relax_wr  = rd_vld_reg && (cmd.mode == spm_pkg::MODE_RELAX) && cand &&
                       (!dvld_reg[rd_idx_reg] || (d_q_reg > w_q_reg));

    assign dist_we    = cmd.seed || relax_wr;
    assign dist_waddr = cmd.seed ? first_reg : rd_idx_reg;
    assign dist_wdata = cmd.seed ? '0 : w_q_reg;

    always_ff @(posedge clk)
    begin
        if (edge_wr)
        begin
            weight_mem[wr_addr] <= edge_weight;
        end
        w_q_reg <= weight_mem[rd_addr_w];
    end

    always_ff @(posedge clk)
    begin
        if (node_wr)
        begin
            value_mem[row_idx] <= node_value;
        end
        v_q_reg <= value_mem[scan_idx];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        d_q_reg <= dist_mem[scan_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= spm_pkg::CFG_RESET;
            pick_limit_reg  <= spm_pkg::CFG_RESET;
            sel_reg         <= '0;
            visited_reg     <= '0;
            dvld_reg        <= '0;
            scan_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            first_reg       <= '0;
            first_found_reg <= 1'b0;
            least_reg       <= '0;
            pick_reg        <= '0;
            best_found_reg  <= 1'b0;
            pending_reg     <= 1'b0;
            pick_base_reg   <= '0;
            rounds_reg      <= '0;
            tree_reg        <= '0;
            vsum_reg        <= '0;
            fail_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            tree_out_reg    <= '0;
            vsum_out_reg    <= '0;
            failed_out_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == spm_pkg::REG_NODE_COUNT)
                begin
                    node_count_reg <= cfg_wr_data;
                end
                else
                begin
                    pick_limit_reg <= cfg_wr_data;
                end
            end

            if (node_wr)
            begin
                sel_reg[row_idx] <= node_selected;
            end

            if (cmd.scan_rst)
            begin
                scan_reg <= '0;
            end
            else if (issue)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            rd_vld_reg <= issue;
            rd_idx_reg <= scan_idx;

            if (cmd.clr_run)
            begin
                visited_reg     <= '0;
                dvld_reg        <= '0;
                vsum_reg        <= '0;
                tree_reg        <= '0;
                rounds_reg      <= '0;
                first_found_reg <= 1'b0;
                fail_reg        <= 1'b0;
            end

            if (init_hit)
            begin
                vsum_reg <= sat_add(vsum_reg, v_q_reg);
                if (!first_found_reg)
                begin
                    first_reg       <= rd_idx_reg;
                    first_found_reg <= 1'b1;
                end
            end

            if (cmd.seed)
            begin
                dvld_reg[first_reg] <= 1'b1;
            end

            if (cmd.scan_rst)
            begin
                best_found_reg <= 1'b0;
                pending_reg    <= 1'b0;
            end
            else if (rd_vld_reg && (cmd.mode == spm_pkg::MODE_FIND) && cand)
            begin
                pending_reg <= 1'b1;
                if (find_hit)
                begin
                    least_reg      <= d_q_reg;
                    pick_reg       <= rd_idx_reg;
                    best_found_reg <= 1'b1;
                end
            end

            if (cmd.take)
            begin
                visited_reg[pick_reg] <= 1'b1;
                tree_reg              <= sat_add(tree_reg, least_reg);
                pick_base_reg         <= AW'(AW'(pick_reg) * AW'(MAX_NODES));
                rounds_reg            <= rounds_reg + 1'b1;
            end

            if (relax_wr)
            begin
                dvld_reg[rd_idx_reg] <= 1'b1;
            end

            if (cmd.set_fail)
            begin
                fail_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg  <= 1'b1;
                tree_out_reg   <= fail_reg ? '0 : tree_reg;
                vsum_out_reg   <= vsum_reg;
                failed_out_reg <= fail_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.scan_done   = (scan_reg == n_eff) && !rd_vld_reg;
    assign sts.first_found = first_found_reg;
    assign sts.best_found  = best_found_reg;
    assign sts.pending     = pending_reg;
    assign sts.rounds_done = (32'(rounds_reg) >= 32'(pick_limit_reg)) || (rounds_reg >= n_eff);
    assign sts.out_busy    = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign tree_weight = tree_out_reg;
    assign value_sum   = vsum_out_reg;
    assign failed      = failed_out_reg;

    `SPM_ASSERT(a_rd_in_scan, clk, rst_n, rd_vld_reg |-> $past(cmd.mode) != spm_pkg::MODE_NONE, "read word outside a scan")
    `SPM_ASSERT(a_take_valid, clk, rst_n, cmd.take |-> best_found_reg && !visited_reg[pick_reg], "pick taken without a fresh candidate")
    `SPM_ASSERT(a_load_free, clk, rst_n, cmd.load_out |-> !(out_valid_reg && out_stall), "result overwrites a waiting word")
    `SPM_ASSERT(a_visit_count, clk, rst_n, $countones(visited_reg) == 32'(rounds_reg), "visited marks disagree with round count")

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Subset Prim MST core testbench
// Loads weight, value and mark words, runs starts across node count and pick
// limit settings, and checks every result word against an in-bench Prim
// predictor. Sender and receiver idle at random; one long receiver hold
// backs the core up into its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD    = 12;
    localparam int MAXN          = 16;
    localparam int START_LATENCY = 640;
    localparam int HOLD_CYCLES   = 400;
    localparam int GROUP_WORDS   = 380;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [16:0] DIST_INF  = 17'h10000;

    typedef struct packed {
        logic [1:0]              op;
        logic [3:0]              row;
        logic [3:0]              col;
        logic [spm_pkg::W_W-1:0] weight;
        logic [spm_pkg::W_W-1:0] value;
        logic                    sel;
    } word_t;

    typedef struct packed {
        logic [spm_pkg::SUM_W-1:0] tree;
        logic [spm_pkg::SUM_W-1:0] vsum;
        logic                      fail;
    } mst_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                op = spm_pkg::OP_EDGE;
    logic [3:0]                row = '0;
    logic [3:0]                col = '0;
    logic [spm_pkg::W_W-1:0]   edge_weight = '0;
    logic [spm_pkg::W_W-1:0]   node_value = '0;
    logic                      node_selected = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [spm_pkg::SUM_W-1:0] tree_weight;
    logic [spm_pkg::SUM_W-1:0] value_sum;
    logic                      failed;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_index = spm_pkg::REG_NODE_COUNT;
    logic [spm_pkg::CFG_W-1:0] cfg_wr_data = '0;

    word_t words_pending[$];
    mst_t  mst_results_due[$];
    word_t cur_word;
    mst_t  due_now;

    bit [spm_pkg::W_W-1:0]   wt_mem [MAXN][MAXN];
    bit [spm_pkg::W_W-1:0]   value_mem [MAXN];
    bit [MAXN-1:0]           sel_mask = '0;
    bit [spm_pkg::CFG_W-1:0] node_count_cfg = spm_pkg::CFG_RESET;
    bit [spm_pkg::CFG_W-1:0] pick_limit_cfg = spm_pkg::CFG_RESET;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int mismatches = 0;

    subset_prim_mst_core #(.MAX_NODES(MAXN)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .row           (row),
        .col           (col),
        .edge_weight   (edge_weight),
        .node_value    (node_value),
        .node_selected (node_selected),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tree_weight   (tree_weight),
        .value_sum     (value_sum),
        .failed        (failed),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [spm_pkg::SUM_W-1:0] clip20(input int v);
        return (v > spm_pkg::SUM_MAX) ? spm_pkg::SUM_MAX : v[spm_pkg::SUM_W-1:0];
    endfunction

    function automatic void prim_predict(input word_t w);
        mst_t          res;
        int            n, first, pick, rounds, i, j, tree, vsum;
        bit [16:0]     best_d [MAXN];
        bit [16:0]     least;
        bit [MAXN-1:0] seen;
        bit            pending, halt;
        case (w.op)
            spm_pkg::OP_EDGE: wt_mem[w.row][w.col] = w.weight;
            spm_pkg::OP_NODE:
            begin
                value_mem[w.row] = w.value;
                sel_mask[w.row] = w.sel;
            end
            spm_pkg::OP_START:
            begin
                n = (int'(node_count_cfg) > MAXN) ? MAXN : int'(node_count_cfg);
                seen = '0;
                tree = 0;
                vsum = 0;
                first = -1;
                halt = 1'b0;
                res.fail = 1'b0;
                for (i = 0; i < MAXN; i++)
                    best_d[i] = DIST_INF;
                for (i = n - 1; i >= 0; i--)
                    if (sel_mask[i])
                        first = i;
                if (first < 0)
                    res.fail = 1'b1;
                else
                begin
                    best_d[first] = '0;
                    for (rounds = 0; rounds < int'(pick_limit_cfg) && rounds < n && !halt;
                         rounds++)
                    begin
                        pick = -1;
                        least = DIST_INF;
                        pending = 1'b0;
                        for (j = 0; j < n; j++)
                            if (sel_mask[j] && !seen[j])
                            begin
                                pending = 1'b1;
                                if (best_d[j] < least)
                                begin
                                    least = best_d[j];
                                    pick = j;
                                end
                            end
                        if (pick < 0)
                        begin
                            res.fail = pending;
                            halt = 1'b1;
                        end
                        else
                        begin
                            seen[pick] = 1'b1;
                            tree = int'(clip20(tree + int'(least)));
                            for (j = 0; j < n; j++)
                                if (!seen[j] && sel_mask[j] && best_d[j] > wt_mem[pick][j])
                                    best_d[j] = 17'(wt_mem[pick][j]);
                        end
                    end
                end
                for (i = 0; i < n; i++)
                    if (sel_mask[i])
                        vsum = int'(clip20(vsum + int'(value_mem[i])));
                res.tree = res.fail ? '0 : tree[spm_pkg::SUM_W-1:0];
                res.vsum = vsum[spm_pkg::SUM_W-1:0];
                mst_results_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // driver: hold the word until accepted, then advance
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                prim_predict(cur_word);
            if (!in_valid || !in_stall)
            begin
                if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_word = words_pending.pop_front();
                    op <= cur_word.op;
                    row <= cur_word.row;
                    col <= cur_word.col;
                    edge_weight <= cur_word.weight;
                    node_value <= cur_word.value;
                    node_selected <= cur_word.sel;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result word, drive receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (mst_results_due.size() == 0)
                begin
                    $error("result word with nothing expected: tree_weight %0d value_sum %0d",
                           tree_weight, value_sum);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    due_now = mst_results_due.pop_front();
                    if (tree_weight !== due_now.tree)
                    begin
                        $error("tree_weight expected %0d actual %0d", due_now.tree, tree_weight);
                        mismatches = mismatches + 1;
                    end
                    if (value_sum !== due_now.vsum)
                    begin
                        $error("value_sum expected %0d actual %0d", due_now.vsum, value_sum);
                        mismatches = mismatches + 1;
                    end
                    if (failed !== due_now.fail)
                    begin
                        $error("failed expected %0d actual %0d", due_now.fail, failed);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (hold_req != hold_ack)
            begin
                hold_ack <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [spm_pkg::W_W-1:0] pick16();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        if (k < 4)
            return spm_pkg::W_W'($urandom_range(3));
        return spm_pkg::W_W'($urandom_range(65535));
    endfunction

    function automatic logic [spm_pkg::CFG_W-1:0] pick_cfg();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return '0;
        if (k == 1)
            return spm_pkg::CFG_W'($urandom_range(17, 31));
        if (k == 2)
            return spm_pkg::CFG_RESET;
        return spm_pkg::CFG_W'($urandom_range(1, 8));
    endfunction

    function automatic void queue_word(input logic [1:0] o, input logic [3:0] r,
                                       input logic [3:0] c,
                                       input logic [spm_pkg::W_W-1:0] wv,
                                       input logic [spm_pkg::W_W-1:0] vv,
                                       input logic s);
        word_t w;
        w.op = o;
        w.row = r;
        w.col = c;
        w.weight = wv;
        w.value = vv;
        w.sel = s;
        words_pending.push_back(w);
    endfunction

    function automatic void queue_start();
        queue_word(spm_pkg::OP_START, 4'($urandom_range(15)), 4'($urandom_range(15)),
                   pick16(), pick16(), 1'($urandom_range(1)));
    endfunction

    // loads then usually a start; returns the count of words that do work
    function automatic int random_sequence();
        int loads, k, counted;
        counted = 0;
        loads = $urandom_range(0, 12);
        repeat (loads)
        begin
            k = $urandom_range(99);
            if (k < 50)
                queue_word(spm_pkg::OP_EDGE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                           pick16(), pick16(), 1'($urandom_range(1)));
            else if (k < 94)
                queue_word(spm_pkg::OP_NODE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                           pick16(), pick16(), 1'($urandom_range(1)));
            else
                queue_word(OP_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)),
                           pick16(), pick16(), 1'($urandom_range(1)));
            if (k < 94)
                counted++;
        end
        if ($urandom_range(9) != 0)
        begin
            queue_start();
            counted++;
        end
        return counted;
    endfunction

    task automatic drain(input int settle);
        @(negedge clk);
        while (words_pending.size() != 0 || in_valid || mst_results_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [spm_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [spm_pkg::CFG_W-1:0] nc,
                              input logic [spm_pkg::CFG_W-1:0] pl);
        drain(START_LATENCY);
        write_reg(spm_pkg::REG_NODE_COUNT, nc);
        node_count_cfg = nc;
        write_reg(spm_pkg::REG_PICK_LIMIT, pl);
        pick_limit_cfg = pl;
    endtask

    task automatic set_idle(input int s, input int r);
        @(posedge clk);
        send_idle_pct <= s;
        recv_idle_pct <= r;
    endtask

    task automatic random_group(input int s, input int r);
        int issued;
        issued = 0;
        set_idle(s, r);
        while (issued < GROUP_WORDS)
        begin
            set_config(pick_cfg(), pick_cfg());
            repeat ($urandom_range(5, 15))
                issued += random_sequence();
        end
    endtask

    initial
    begin
        int r, c;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_config(spm_pkg::CFG_RESET, spm_pkg::CFG_RESET);
        set_idle(31, 55);
        for (r = 0; r < MAXN; r++)
            for (c = 0; c < MAXN; c++)
                queue_word(spm_pkg::OP_EDGE, 4'(r), 4'(c), pick16(), '0, 1'b0);
        for (r = 0; r < MAXN; r++)
            queue_word(spm_pkg::OP_NODE, 4'(r), '0, '0, pick16(), 1'b0);

        // empty selection, unused op, extremes, ties
        queue_word(spm_pkg::OP_START, '0, '0, '0, '0, 1'b0);
        queue_word(OP_UNUSED, '1, '1, '1, '1, 1'b1);
        queue_word(spm_pkg::OP_NODE, 4'd0, '0, '0, '1, 1'b1);
        queue_word(spm_pkg::OP_NODE, 4'd15, '0, '0, '0, 1'b1);
        queue_word(spm_pkg::OP_EDGE, 4'd0, 4'd15, '1, '0, 1'b0);
        queue_word(spm_pkg::OP_START, '1, '1, '1, '1, 1'b1);
        queue_word(spm_pkg::OP_NODE, 4'd6, '0, '0, 16'd1, 1'b1);
        queue_word(spm_pkg::OP_NODE, 4'd9, '0, '0, 16'd2, 1'b1);
        queue_word(spm_pkg::OP_EDGE, 4'd0, 4'd6, 16'd5, '0, 1'b0);
        queue_word(spm_pkg::OP_EDGE, 4'd0, 4'd9, 16'd5, '0, 1'b0);
        queue_word(spm_pkg::OP_EDGE, 4'd6, 4'd9, '0, '0, 1'b0);
        queue_word(spm_pkg::OP_EDGE, 4'd6, 4'd15, '0, '0, 1'b0);
        queue_word(spm_pkg::OP_START, '0, '0, '0, '0, 1'b0);
        queue_word(spm_pkg::OP_NODE, 4'd0, '0, '0, '0, 1'b0);
        queue_word(spm_pkg::OP_START, '0, '0, '0, '0, 1'b0);

        set_config('0, spm_pkg::CFG_RESET);
        queue_start();
        set_config(spm_pkg::CFG_RESET, '0);
        queue_start();
        set_config('1, '1);
        queue_start();
        set_config(spm_pkg::CFG_RESET, 5'd1);
        queue_start();
        set_config(5'd1, spm_pkg::CFG_RESET);
        queue_start();
        queue_word(spm_pkg::OP_NODE, 4'd0, '0, '0, 16'd7, 1'b1);
        queue_start();
        set_config(5'd7, 5'd3);
        queue_start();

        random_group(31, 55);
        random_group(55, 31);

        // hold the receiver off while starts keep coming
        set_idle(0, 0);
        set_config(5'd3, 5'd3);
        @(posedge clk);
        hold_req <= hold_req + 1;
        repeat (24) queue_start();
        random_group(0, 0);

        drain(START_LATENCY);
        if (mismatches == 0 && mst_results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 1200000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
